### sv/image_scale_2x_four_modes_macros.svh
// assertion helpers shared by the scaler modules
`ifndef IMAGE_SCALE_2X_FOUR_MODES_MACROS_SVH
`define IMAGE_SCALE_2X_FOUR_MODES_MACROS_SVH

// same-cycle implication, checked out of reset
`define IS2X_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("is2x check failed");

// next-cycle implication, checked out of reset
`define IS2X_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("is2x check failed");

`endif

### sv/is2x_pkg.sv
`default_nettype none
package is2x_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;

    localparam int unsigned CFG_DIM_W  = 12;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned COORD_W    = 12;
    localparam int unsigned SLOTS      = 9;

    localparam logic [1:0] MODE_BOX   = 2'd0;
    localparam logic [1:0] MODE_SKIP  = 2'd1;
    localparam logic [1:0] MODE_BILIN = 2'd2;
    localparam logic [1:0] MODE_REPL  = 2'd3;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 12'd480;

    typedef logic [23:0] pix_t;

    // one input pixel's results: 3x3 slots around a base position
    typedef struct packed {
        logic [SLOTS-1:0]   mask;
        logic [COORD_W-1:0] base_row;
        logic [COORD_W-1:0] base_col;
        pix_t               px_diag;
        pix_t               px_vert;
        pix_t               px_horz;
        pix_t               px_main;
    } job_t;

    function automatic pix_t avg2(input pix_t a, input pix_t b);
        pix_t       r;
        logic [8:0] s;
        for (int k = 0; k < 3; k++) begin
            s = 9'(a[8*k +: 8]) + 9'(b[8*k +: 8]);
            r[8*k +: 8] = s[8:1];
        end
        return r;
    endfunction

    function automatic pix_t avg4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
        pix_t       r;
        logic [9:0] s;
        for (int k = 0; k < 3; k++) begin
            s = 10'(a[8*k +: 8]) + 10'(b[8*k +: 8]) + 10'(c[8*k +: 8]) + 10'(d[8*k +: 8]);
            r[8*k +: 8] = s[9:2];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/is2x_line_buf.sv
`default_nettype none
module is2x_line_buf #(
    parameter int unsigned MAX_WIDTH = is2x_pkg::MAX_WIDTH_DEF,
    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic           aclk,
    input  wire logic           rd_en,
    input  wire logic [AW-1:0]  rd_addr,
    output is2x_pkg::pix_t      rd_data,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire is2x_pkg::pix_t wr_data
);

    is2x_pkg::pix_t mem [MAX_WIDTH];
    is2x_pkg::pix_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### sv/is2x_emit.sv
`default_nettype none
`include "image_scale_2x_four_modes_macros.svh"
module is2x_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load_en,
    input  wire is2x_pkg::job_t                load_job,
    output logic                               free,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [is2x_pkg::COORD_W-1:0]       m_out_row,
    output logic [is2x_pkg::COORD_W-1:0]       m_out_col,
    output logic [7:0]                         m_out_red,
    output logic [7:0]                         m_out_green,
    output logic [7:0]                         m_out_blue,
    output logic                               m_last_of_run
);

    is2x_pkg::job_t               job_reg;
    logic [is2x_pkg::SLOTS-1:0]   mask_reg;
    logic [is2x_pkg::SLOTS-1:0]   mask_rest;
    logic [3:0]                   slot;
    logic [1:0]                   roff;
    logic [1:0]                   coff;
    is2x_pkg::pix_t               px;

    assign mask_rest     = mask_reg & (mask_reg - is2x_pkg::SLOTS'(1));
    assign m_valid       = (mask_reg != '0);
    assign m_last_of_run = (mask_rest == '0);
    assign free          = !m_valid || (m_ready && m_last_of_run);

    always_comb begin
        slot = '0;
        for (int k = is2x_pkg::SLOTS - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                slot = 4'(k);
            end
        end
    end

    // slot order: row above, own row, row below; left, center, right in each
    always_comb begin
        case (slot)
            4'd0: begin roff = 2'd0; coff = 2'd0; px = job_reg.px_diag; end
            4'd1: begin roff = 2'd0; coff = 2'd1; px = job_reg.px_vert; end
            4'd2: begin roff = 2'd0; coff = 2'd2; px = job_reg.px_vert; end
            4'd3: begin roff = 2'd1; coff = 2'd0; px = job_reg.px_horz; end
            4'd4: begin roff = 2'd1; coff = 2'd1; px = job_reg.px_main; end
            4'd5: begin roff = 2'd1; coff = 2'd2; px = job_reg.px_main; end
            4'd6: begin roff = 2'd2; coff = 2'd0; px = job_reg.px_horz; end
            4'd7: begin roff = 2'd2; coff = 2'd1; px = job_reg.px_main; end
            4'd8: begin roff = 2'd2; coff = 2'd2; px = job_reg.px_main; end
            default: begin roff = 2'd1; coff = 2'd1; px = job_reg.px_main; end
        endcase
    end

    assign m_out_row   = job_reg.base_row + is2x_pkg::COORD_W'(roff) - is2x_pkg::COORD_W'(1);
    assign m_out_col   = job_reg.base_col + is2x_pkg::COORD_W'(coff) - is2x_pkg::COORD_W'(1);
    assign m_out_red   = px[23:16];
    assign m_out_green = px[15:8];
    assign m_out_blue  = px[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (load_en) begin
            mask_reg <= load_job.mask;
        end else if (m_valid && m_ready) begin
            mask_reg <= mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            job_reg <= load_job;
        end
    end

    `IS2X_ASSERT_SAME(no_job_overwrite, load_en, free)
    `IS2X_ASSERT_NEXT(run_continues, m_valid && m_ready && !m_last_of_run, m_valid)

endmodule
`default_nettype wire

### sv/image_scale_2x_four_modes.sv
// channel   | direction | payload                                        | handshake
// s_        | in        | s_red, s_green, s_blue                         | s_valid/s_ready
// m_        | out       | m_out_row, m_out_col, m_out_{red,green,blue},  | m_valid/m_ready
//           |           | m_last_of_run                                  |
// apb       | in        | mode, image_width, image_height at 0x0/0x4/0x8 | psel/penable
//
// one result beat per cycle from the emit register while m_ready is high; a pixel yields
// no result or one scaling down, 4 typical and up to 9 scaling up
// first beat valid once the pixel has passed the accept stage (line buffer read), then the emit load
// synchronous reset clears counters, neighbor pixels and config; line buffer not cleared
// m_ready low holds the current beat; one more pixel is taken and parked, then s_ready drops
`default_nettype none
`include "image_scale_2x_four_modes_macros.svh"
module image_scale_2x_four_modes #(
    parameter int unsigned MAX_WIDTH  = is2x_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = is2x_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [is2x_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_red,
    input  wire logic [7:0]                        s_green,
    input  wire logic [7:0]                        s_blue,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [is2x_pkg::COORD_W-1:0]           m_out_row,
    output logic [is2x_pkg::COORD_W-1:0]           m_out_col,
    output logic [7:0]                             m_out_red,
    output logic [7:0]                             m_out_green,
    output logic [7:0]                             m_out_blue,
    output logic                                   m_last_of_run
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned MW = (CW > RW) ? CW : RW;
    localparam int unsigned XW = ((MW > is2x_pkg::CFG_DIM_W) ? MW : is2x_pkg::CFG_DIM_W) + 1;
    localparam int unsigned OW = is2x_pkg::COORD_W;

    // config
    logic [1:0]                     mode_reg;
    logic [is2x_pkg::CFG_DIM_W-1:0] width_reg;
    logic [is2x_pkg::CFG_DIM_W-1:0] height_reg;
    logic                           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= is2x_pkg::MODE_BOX;
            width_reg  <= is2x_pkg::WIDTH_RST;
            height_reg <= is2x_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                is2x_pkg::REG_MODE:   mode_reg   <= pwdata[1:0];
                is2x_pkg::REG_WIDTH:  width_reg  <= pwdata[is2x_pkg::CFG_DIM_W-1:0];
                is2x_pkg::REG_HEIGHT: height_reg <= pwdata[is2x_pkg::CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            is2x_pkg::REG_MODE:   prdata = 32'(mode_reg);
            is2x_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            is2x_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // effective size, clamped to 1..max
    logic [XW-1:0] w_eff;
    logic [XW-1:0] h_eff;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = XW'(1);
        end else if (XW'(width_reg) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = XW'(1);
        end else if (XW'(height_reg) > XW'(MAX_HEIGHT)) begin
            h_eff = XW'(MAX_HEIGHT);
        end else begin
            h_eff = XW'(height_reg);
        end
    end

    // position counters and accept stage
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [XW-1:0]  col_x;
    logic [XW-1:0]  row_x;
    logic [XW-1:0]  row_inc;
    logic           wrap_c;
    logic           last_col;
    logic           last_row;
    logic [OW-1:0]  base_row;
    logic [OW-1:0]  base_col;
    logic           s_acc;
    logic           a_adv;
    logic           emit_free;

    assign wrap_c   = XW'(col_reg) >= w_eff;
    assign col_x    = wrap_c ? '0 : XW'(col_reg);
    assign row_inc  = wrap_c ? XW'(row_reg) + XW'(1) : XW'(row_reg);
    assign row_x    = (row_inc >= h_eff) ? '0 : row_inc;
    assign last_col = (col_x + XW'(1)) == w_eff;
    assign last_row = (row_x + XW'(1)) == h_eff;

    always_comb begin
        if (mode_reg == is2x_pkg::MODE_BOX || mode_reg == is2x_pkg::MODE_SKIP) begin
            base_row = OW'(row_x >> 1);
            base_col = OW'(col_x >> 1);
        end else begin
            base_row = OW'({row_x, 1'b0});
            base_col = OW'({col_x, 1'b0});
        end
    end

    logic           a_valid_reg;
    is2x_pkg::pix_t a_cur_reg;
    logic [CW-1:0]  a_col_reg;
    logic [OW-1:0]  a_brow_reg;
    logic [OW-1:0]  a_bcol_reg;
    logic           a_rp_reg;
    logic           a_cp_reg;
    logic           a_lc_reg;
    logic           a_lr_reg;
    logic           a_rodd_reg;
    logic           a_codd_reg;
    logic           a_fwd_reg;

    assign a_adv   = a_valid_reg && emit_free;
    assign s_ready = !a_valid_reg || a_adv;
    assign s_acc   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                a_valid_reg <= 1'b1;
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : RW'(row_x + XW'(1));
                end else begin
                    col_reg <= CW'(col_x + XW'(1));
                    row_reg <= RW'(row_x);
                end
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_cur_reg  <= {s_red, s_green, s_blue};
            a_col_reg  <= CW'(col_x);
            a_brow_reg <= base_row;
            a_bcol_reg <= base_col;
            a_rp_reg   <= (row_x != '0);
            a_cp_reg   <= (col_x != '0);
            a_lc_reg   <= last_col;
            a_lr_reg   <= last_row;
            a_rodd_reg <= row_x[0];
            a_codd_reg <= col_x[0];
            // pixel ahead writes the same entry at this edge
            a_fwd_reg  <= a_adv && (CW'(col_x) == a_col_reg);
        end
    end

    // line buffer
    is2x_pkg::pix_t up_mem;

    is2x_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (CW'(col_x)),
        .rd_data (up_mem),
        .wr_en   (a_adv),
        .wr_addr (a_col_reg),
        .wr_data (a_cur_reg)
    );

    // neighbors and result values
    is2x_pkg::pix_t left_reg;
    is2x_pkg::pix_t above_left_reg;
    is2x_pkg::pix_t up;
    is2x_pkg::pix_t hcur;
    is2x_pkg::job_t job;

    assign up   = a_fwd_reg ? left_reg : up_mem;
    assign hcur = a_cp_reg ? is2x_pkg::avg2(left_reg, a_cur_reg) : a_cur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            above_left_reg <= '0;
        end else if (a_adv) begin
            left_reg       <= a_cur_reg;
            above_left_reg <= up;
        end
    end

    always_comb begin
        job.base_row = a_brow_reg;
        job.base_col = a_bcol_reg;
        job.px_diag  = is2x_pkg::avg2(is2x_pkg::avg2(above_left_reg, up), hcur);
        job.px_vert  = is2x_pkg::avg2(up, a_cur_reg);
        job.px_horz  = hcur;
        job.px_main  = a_cur_reg;
        job.mask     = '0;
        case (mode_reg)
            is2x_pkg::MODE_BOX: begin
                job.px_main = is2x_pkg::avg4(above_left_reg, up, left_reg, a_cur_reg);
                job.mask[4] = a_rodd_reg && a_codd_reg;
            end
            is2x_pkg::MODE_SKIP: begin
                job.mask[4] = !a_rodd_reg && !a_codd_reg && !a_lr_reg && !a_lc_reg;
            end
            is2x_pkg::MODE_BILIN: begin
                job.mask = {a_lr_reg && a_lc_reg, a_lr_reg, a_lr_reg && a_cp_reg,
                            a_lc_reg, 1'b1, a_cp_reg,
                            a_rp_reg && a_lc_reg, a_rp_reg, a_rp_reg && a_cp_reg};
            end
            is2x_pkg::MODE_REPL: begin
                job.px_vert = up;
                job.mask    = {a_lr_reg, a_lr_reg, 1'b0,
                               1'b1, 1'b1, 1'b0,
                               a_rp_reg, a_rp_reg, 1'b0};
            end
            default: ;
        endcase
    end

    is2x_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load_en       (a_adv),
        .load_job      (job),
        .free          (emit_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_last_of_run (m_last_of_run)
    );

    `IS2X_ASSERT_SAME(accept_into_full_stage, s_valid && s_ready && a_valid_reg, a_adv)

endmodule
`default_nettype wire
